[hdl/lz_pkg.sv]
// ----------------------------------------------------------------------------
// lz_pkg - shared types, constants and helpers of the Lorenz Euler stepper
// Fixed-point widths, register indexes, multiplier control and the
// saturation functions used by the sequencer and the multiply unit.
// ----------------------------------------------------------------------------
package lz_pkg;

   // default fraction bits of the coordinate format
   localparam int LZ_FRAC_BITS = 24;
   // fraction bits of the dt register
   localparam int LZ_DT_BITS = 24;
   localparam int LZ_HUE_BITS = 16;

   // register indexes of the configuration port
   localparam logic [2:0] REG_SIGMA = 3'd0;
   localparam logic [2:0] REG_RHO   = 3'd1;
   localparam logic [2:0] REG_BETA  = 3'd2;
   localparam logic [2:0] REG_DT    = 3'd3;
   localparam logic [2:0] REG_HUE   = 3'd4;

   // control of the shared multiply unit
   typedef struct packed {
      logic issue;     // load a new product
      logic dt_scale;  // shift by the dt width instead of the fraction width
   } lz_mul_ctl_type;

   // clamp a 64-bit signed value to the 32-bit signed range
   function automatic logic signed [31:0] sat64to32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // clamp a 33-bit signed sum or difference to 32 bits
   function automatic logic signed [31:0] sat33to32(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v[32] != v[31]) begin
         r = v[32] ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[hdl/lz_mul_unit.sv]
// ----------------------------------------------------------------------------
// lz_mul_unit - shared fixed-point multiplier
// Registers the exact 32x32 signed product, then floors it by the fraction
// or dt width and clamps the result to 32 bits for the writeback.
// ----------------------------------------------------------------------------
module lz_mul_unit
   import lz_pkg::*;
#(
   parameter int FRAC_BITS = LZ_FRAC_BITS
) (
   input  logic                  clock,
   input  lz_mul_ctl_type        ctl,
   input  logic signed [31:0]    op_a,
   input  logic signed [31:0]    op_b,
   output logic signed [31:0]    result
);

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;
   logic               dt_sel_ff;
   logic signed [63:0] shifted;

   assign prod_in = op_a * op_b;

   // capture the product and its scaling on issue, hold otherwise
   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         prod_ff   <= prod_in;
         dt_sel_ff <= ctl.dt_scale;
      end
   end

   // arithmetic shift floors toward minus infinity
   always_comb begin
      if (dt_sel_ff) begin
         shifted = prod_ff >>> LZ_DT_BITS;
      end else begin
         shifted = prod_ff >>> FRAC_BITS;
      end
      result = sat64to32(shifted);
   end

endmodule

[hdl/lorenz_euler_step.sv]
// ----------------------------------------------------------------------------
// lorenz_euler_step - Lorenz system forward-Euler stepper with hue colour
// Keeps the point in signed fixed point and advances it one Euler step per
// request with tick set; every request returns one point and one colour.
// ----------------------------------------------------------------------------
// A request with tick set occupies the block from acceptance until the
// sequencer is back in idle: a difference step forms y-x and rho-z, seven
// products go one per cycle through the single registered 32x32 multiplier
// (four for the derivatives, three for the dt scaling), and a finish step
// writes z back, advances the hue and loads the response register. A request
// with tick clear is answered from the current state and can be accepted
// every cycle while no held response is stalled. The response register lets a
// new request in while the previous response drains; req_stall is high while
// a step is in progress or while a held response has not been taken.
module lorenz_euler_step
   import lz_pkg::*;
#(
   parameter int FRAC_BITS = LZ_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_tick,
   // response channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_pos_x,
   output logic signed [31:0]  rsp_pos_y,
   output logic signed [31:0]  rsp_pos_z,
   output logic [15:0]         rsp_red_level,
   output logic [16:0]         rsp_green_blue_level,
   // configuration port
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);

   // reset values; the coefficients and the point follow the fraction width
   localparam logic signed [63:0] ONE       = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] SIGMA_RST = sat64to32(ONE * 64'sd10);
   localparam logic signed [31:0] RHO_RST   = sat64to32(ONE * 64'sd28);
   localparam logic signed [31:0] BETA_RST  = sat64to32((ONE * 64'sd8 + 64'sd1) / 64'sd3);
   localparam logic signed [31:0] POS_RST   = sat64to32(ONE / 64'sd100);
   localparam logic [23:0]        DT_RST    = 24'd167772;
   localparam logic [15:0]        HUE_RST   = 16'd655;

   // sequencer steps
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DIFF   = 4'd1;
   localparam logic [3:0] ST_MUL_FX = 4'd2;
   localparam logic [3:0] ST_MUL_T1 = 4'd3;
   localparam logic [3:0] ST_MUL_T2 = 4'd4;
   localparam logic [3:0] ST_MUL_T3 = 4'd5;
   localparam logic [3:0] ST_DT_X   = 4'd6;
   localparam logic [3:0] ST_DT_Y   = 4'd7;
   localparam logic [3:0] ST_DT_Z   = 4'd8;
   localparam logic [3:0] ST_FINISH = 4'd9;

   logic [3:0]         state_ff, state_in;

   logic signed [31:0] sigma_ff, rho_ff, beta_ff;
   logic [23:0]        dt_ff;
   logic [15:0]        hue_step_ff;

   logic signed [31:0] x_ff, y_ff, z_ff;
   logic [15:0]        hue_ff;

   logic signed [31:0] dxy_ff, drz_ff;
   logic signed [31:0] fx_ff, fy_ff, fz_ff;

   logic               rsp_valid_ff;
   logic signed [31:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [15:0]        red_ff;
   logic [16:0]        gb_ff;

   lz_mul_ctl_type     mul_ctl;
   logic signed [31:0] op_a, op_b, mul_res;

   logic               out_free, accept, load_now, load_step;
   logic signed [31:0] z_new;
   logic [16:0]        hue_sum;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign load_now  = accept && !req_tick;
   assign load_step = (state_ff == ST_FINISH) && out_free;

   assign z_new   = sat33to32({z_ff[31], z_ff} + {mul_res[31], mul_res});
   assign hue_sum = {1'b0, hue_ff} + {1'b0, hue_step_ff};

   // pick multiplier operands for the step being issued
   always_comb begin
      op_a             = x_ff;
      op_b             = y_ff;
      mul_ctl.issue    = state_ff inside {[ST_MUL_FX:ST_DT_Z]};
      mul_ctl.dt_scale = state_ff inside {[ST_DT_X:ST_DT_Z]};
      case (state_ff)
         ST_MUL_FX: begin
            op_a = sigma_ff;
            op_b = dxy_ff;
         end
         ST_MUL_T1: begin
            op_a = x_ff;
            op_b = drz_ff;
         end
         ST_MUL_T2: begin
            op_a = x_ff;
            op_b = y_ff;
         end
         ST_MUL_T3: begin
            op_a = beta_ff;
            op_b = z_ff;
         end
         ST_DT_X: begin
            op_a = fx_ff;
            op_b = {8'd0, dt_ff};
         end
         ST_DT_Y: begin
            op_a = fy_ff;
            op_b = {8'd0, dt_ff};
         end
         ST_DT_Z: begin
            op_a = fz_ff;
            op_b = {8'd0, dt_ff};
         end
         default: begin
            op_a = x_ff;
            op_b = y_ff;
         end
      endcase
   end

   lz_mul_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mul (
      .clock  (clock),
      .ctl    (mul_ctl),
      .op_a   (op_a),
      .op_b   (op_b),
      .result (mul_res)
   );

   // advance the sequencer; hold the last step until the response slot is free
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_tick) begin
               state_in = ST_DIFF;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = state_ff + 4'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sigma_ff    <= SIGMA_RST;
         rho_ff      <= RHO_RST;
         beta_ff     <= BETA_RST;
         dt_ff       <= DT_RST;
         hue_step_ff <= HUE_RST;
      end else if (csr_write) begin
         case (csr_index)
            REG_SIGMA: sigma_ff    <= csr_data;
            REG_RHO:   rho_ff      <= csr_data;
            REG_BETA:  beta_ff     <= csr_data;
            REG_DT:    dt_ff       <= csr_data[23:0];
            REG_HUE:   hue_step_ff <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // intermediate terms: differences and derivatives
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_DIFF: begin
            dxy_ff <= sat33to32({y_ff[31], y_ff} - {x_ff[31], x_ff});
            drz_ff <= sat33to32({rho_ff[31], rho_ff} - {z_ff[31], z_ff});
         end
         ST_MUL_T1: fx_ff <= mul_res;
         ST_MUL_T2: fy_ff <= sat33to32({mul_res[31], mul_res} - {y_ff[31], y_ff});
         ST_MUL_T3: fz_ff <= mul_res;
         ST_DT_X:   fz_ff <= sat33to32({fz_ff[31], fz_ff} - {mul_res[31], mul_res});
         default: begin
         end
      endcase
   end

   // point and hue state
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff   <= POS_RST;
         y_ff   <= POS_RST;
         z_ff   <= POS_RST;
         hue_ff <= '0;
      end else begin
         if (state_ff == ST_DT_Y) begin
            x_ff <= sat33to32({x_ff[31], x_ff} + {mul_res[31], mul_res});
         end
         if (state_ff == ST_DT_Z) begin
            y_ff <= sat33to32({y_ff[31], y_ff} + {mul_res[31], mul_res});
         end
         if (load_step) begin
            z_ff   <= z_new;
            hue_ff <= hue_sum[16] ? 16'd0 : hue_sum[15:0];
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_now || load_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_now || load_step) begin
         pos_x_ff <= x_ff;
         pos_y_ff <= y_ff;
         pos_z_ff <= load_step ? z_new : z_ff;
         red_ff   <= hue_ff;
         gb_ff    <= 17'h10000 - {1'b0, hue_ff};
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pos_x            = pos_x_ff;
   assign rsp_pos_y            = pos_y_ff;
   assign rsp_pos_z            = pos_z_ff;
   assign rsp_red_level        = red_ff;
   assign rsp_green_blue_level = gb_ff;

endmodule

[verif/tb_lorenz_euler_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lorenz_euler_step - self-checking bench of the Lorenz Euler stepper
// Sends tick and report-only requests with random gaps against a receiver
// that stalls at random. A bit-exact fixed-point predictor computes each
// point and colour, and a monitor compares every response in order.
// ----------------------------------------------------------------------------
module tb_lorenz_euler_step;
   import lz_pkg::*;

   localparam int CYCLE_LIMIT = 500000;
   localparam int IDLE_PCT    = 38;
   localparam longint HUE_ONE = 65536;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [15:0] red;
      logic [16:0] green_blue;
   } orbit_point_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_tick;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_pos_x;
   logic signed [31:0] rsp_pos_y;
   logic signed [31:0] rsp_pos_z;
   logic [15:0]        rsp_red_level;
   logic [16:0]        rsp_green_blue_level;
   logic               csr_write;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;

   // predictor copy of configuration and state
   longint      gain_sigma, gain_rho, gain_beta, dt_step;
   int unsigned hue_inc;
   longint      orbit_x, orbit_y, orbit_z;
   int unsigned hue_now;

   orbit_point_type expected_points[$];
   int              error_count;
   int              cycle_count;
   bit              steady_run;

   lorenz_euler_step dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_tick             (req_tick),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_pos_x            (rsp_pos_x),
      .rsp_pos_y            (rsp_pos_y),
      .rsp_pos_z            (rsp_pos_z),
      .rsp_red_level        (rsp_red_level),
      .rsp_green_blue_level (rsp_green_blue_level),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // fixed-point predictor
   // ------------------------------------------------------------------
   function automatic longint clamp_s32(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // exact product, floor shift by the fraction width, clamp
   function automatic longint fixed_mul(input longint a, input longint b);
      return clamp_s32((a * b) >>> LZ_FRAC_BITS);
   endfunction

   function automatic longint scale_by_dt(input longint d);
      return clamp_s32((d * dt_step) >>> LZ_DT_BITS);
   endfunction

   function automatic void reset_orbit_model();
      gain_sigma = 64'sd167772160;
      gain_rho   = 64'sd469762048;
      gain_beta  = 64'sd44739243;
      dt_step    = 167772;
      hue_inc    = 655;
      orbit_x    = 167772;
      orbit_y    = 167772;
      orbit_z    = 167772;
      hue_now    = 0;
   endfunction

   // advance the point for one accepted request and queue the response
   function automatic void advance_orbit(input logic tick_bit);
      orbit_point_type pt;
      longint          dx, dy, dz;
      int unsigned     hue_before, hue_sum;
      hue_before = hue_now;
      if (tick_bit) begin
         dx = fixed_mul(gain_sigma, clamp_s32(orbit_y - orbit_x));
         dy = clamp_s32(fixed_mul(orbit_x, clamp_s32(gain_rho - orbit_z)) - orbit_y);
         dz = clamp_s32(fixed_mul(orbit_x, orbit_y) - fixed_mul(gain_beta, orbit_z));
         orbit_x = clamp_s32(orbit_x + scale_by_dt(dx));
         orbit_y = clamp_s32(orbit_y + scale_by_dt(dy));
         orbit_z = clamp_s32(orbit_z + scale_by_dt(dz));
         hue_sum = hue_now + hue_inc;
         // hue reaching one drops back to zero
         hue_now = (hue_sum >= HUE_ONE) ? 0 : hue_sum;
      end
      pt.x          = orbit_x[31:0];
      pt.y          = orbit_y[31:0];
      pt.z          = orbit_z[31:0];
      pt.red        = hue_before[15:0];
      pt.green_blue = 17'(HUE_ONE - hue_before);
      expected_points = {expected_points, pt};
   endfunction

   function automatic void apply_register(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         REG_SIGMA: gain_sigma = longint'($signed(value));
         REG_RHO:   gain_rho   = longint'($signed(value));
         REG_BETA:  gain_beta  = longint'($signed(value));
         REG_DT:    dt_step    = value[23:0];
         REG_HUE:   hue_inc    = value[15:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------
   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endtask

   task automatic check_point();
      orbit_point_type want;
      if (expected_points.size() == 0) begin
         error_count++;
         $display("%0t: unexpected response, actual x %h y %h z %h", $time,
                  rsp_pos_x, rsp_pos_y, rsp_pos_z);
      end else begin
         want = expected_points.pop_front();
         compare_field("pos_x", want.x, rsp_pos_x);
         compare_field("pos_y", want.y, rsp_pos_y);
         compare_field("pos_z", want.z, rsp_pos_z);
         compare_field("red_level", {16'd0, want.red}, {16'd0, rsp_red_level});
         compare_field("green_blue_level", {15'd0, want.green_blue},
                       {15'd0, rsp_green_blue_level});
      end
   endtask

   // predict on request acceptance, then check on response acceptance
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            advance_orbit(req_tick);
         end
         if (rsp_valid && !rsp_stall) begin
            check_point();
         end
      end
   end

   // random receiver backpressure
   always @(negedge clock) begin
      rsp_stall <= !steady_run && ($urandom_range(99) < IDLE_PCT);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   // send one request, with an optional gap, and hold until accepted
   task automatic issue_request(input logic tick_bit);
      int gap;
      gap = 0;
      if (!steady_run && $urandom_range(99) < IDLE_PCT) begin
         gap = $urandom_range(1, 6);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_tick  <= tick_bit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid and wait until every response has come back
   task automatic wait_for_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      apply_register(idx, value);
   endtask

   task automatic run_requests(input int count, input int tick_pct);
      for (int i = 0; i < count; i++) begin
         issue_request($urandom_range(99) < tick_pct);
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // reset point and default coefficients, report-only around steps
   task automatic test_reset_point();
      issue_request(1'b0);
      repeat (4) issue_request(1'b1);
      issue_request(1'b0);
      wait_for_idle();
   endtask

   // hue landing exactly on one, overshooting one, and a zero increment
   task automatic test_hue_rollover();
      write_register(REG_HUE, 32'd16384);
      repeat (5) issue_request(1'b1);
      wait_for_idle();
      write_register(REG_HUE, 32'd65535);
      repeat (3) issue_request(1'b1);
      wait_for_idle();
      write_register(REG_HUE, 32'd0);
      issue_request(1'b1);
      wait_for_idle();
      write_register(REG_HUE, 32'd655);
   endtask

   // random orbits with coefficients near the classic attractor
   task automatic test_random_orbits();
      for (int phase = 0; phase < 6; phase++) begin
         write_register(REG_SIGMA, $urandom_range(32'd5 << 24, 32'd16 << 24));
         write_register(REG_RHO, $urandom_range(32'd0, 32'd48 << 24));
         write_register(REG_BETA, $urandom_range(32'd1 << 24, 32'd4 << 24));
         write_register(REG_DT, $urandom_range(16777, 335544));
         write_register(REG_HUE, $urandom_range(0, 65535));
         // one long stretch with neither side idling
         steady_run = (phase == 2);
         run_requests(220, 85);
         wait_for_idle();
         steady_run = 1'b0;
      end
   endtask

   // extreme coefficients drive the point into saturation
   task automatic test_coefficient_extremes();
      write_register(REG_SIGMA, 32'h7fffffff);
      write_register(REG_RHO, 32'h80000000);
      write_register(REG_BETA, 32'h7fffffff);
      write_register(REG_DT, 32'h00ffffff);
      repeat (3) issue_request(1'b1);
      wait_for_idle();
      write_register(REG_SIGMA, 32'h80000000);
      write_register(REG_RHO, 32'h7fffffff);
      write_register(REG_BETA, 32'h80000000);
      repeat (3) issue_request(1'b1);
      wait_for_idle();
      // a zero step freezes the point but still advances the hue
      write_register(REG_DT, 32'd0);
      issue_request(1'b1);
      issue_request(1'b0);
      wait_for_idle();
      // unused indexes must change nothing
      for (int idx = REG_HUE + 1; idx < 8; idx++) begin
         write_register(3'(idx), $urandom);
      end
      issue_request(1'b1);
      wait_for_idle();
   endtask

   // fully random register contents, upper bits and unused indexes included
   task automatic test_random_registers();
      for (int phase = 0; phase < 4; phase++) begin
         for (int idx = 0; idx < 8; idx++) begin
            write_register(3'(idx), $urandom);
         end
         run_requests(100, 60);
         wait_for_idle();
      end
   endtask

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_tick    = 1'b0;
      rsp_stall   = 1'b0;
      csr_write   = 1'b0;
      csr_index   = REG_SIGMA;
      csr_data    = 32'd0;
      error_count = 0;
      cycle_count = 0;
      steady_run  = 1'b0;
      reset_orbit_model();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_point();
      test_hue_rollover();
      test_random_orbits();
      test_coefficient_extremes();
      test_random_registers();

      wait_for_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
